/* src/bphs_pkg.sv */
`timescale 1ns / 1ps
package bphs_pkg;

	localparam int MAX_PATTERN_BYTES = 8;
	localparam int ADDRESS_BITS      = 48;
	localparam int HIST_BITS         = 8 * MAX_PATTERN_BYTES;

	localparam int PATTERN_BITS = 64;
	localparam int LEN_BITS     = 4;
	localparam int COUNT_BITS   = 16;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 2;

	localparam logic [LEN_BITS-1:0]   PATTERN_LENGTH_RESET = 4'd1;
	localparam logic [COUNT_BITS-1:0] HIT_LIMIT_RESET      = 16'd1024;

	localparam logic KIND_HIT     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PATTERN_BYTES  = 2'd0,
		CFG_PATTERN_LENGTH = 2'd1,
		CFG_HIT_LIMIT      = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0]              data_byte;
		logic [ADDRESS_BITS-1:0] region_base;
		logic [ADDRESS_BITS-1:0] region_limit;
		logic                    region_first;
		logic                    scan_last;
	} scan_item_t;

	typedef struct packed {
		logic                    result_kind;
		logic [ADDRESS_BITS-1:0] hit_address;
		logic [ADDRESS_BITS-1:0] hit_region_base;
		logic [ADDRESS_BITS-1:0] hit_region_limit;
		logic [COUNT_BITS-1:0]   hit_number;
		logic                    is_last;
	} result_t;

endpackage

/* src/bphs_ifs.sv */
`timescale 1ns / 1ps
interface bphs_scan_if;
	import bphs_pkg::*;
	logic       valid;
	logic       ready;
	scan_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bphs_result_if;
	import bphs_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface bphs_cfg_if;
	import bphs_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* src/byte_pattern_hit_scanner_unit.sv */
// Channel   Dir   Payload                          Request accepted on
// scan      in    byte, region bounds, flags       valid && ready
// result    out   hit record or scan summary       valid && ready
// cfg       in    register index, write data       valid && ready (ready always high)
//
// One byte is taken per cycle while scan.ready is high and held in the input stage.
// Its results then enter the result queue; a last-byte hit adds the hit, then the summary.
// Throughput is set by the single input stage and a three-entry result queue.
// Reset loads the register defaults and clears the scan state at once, no clearing pass.
// A stalled result side fills the queue, then holds the input stage and drops scan.ready.
`timescale 1ns / 1ps
module byte_pattern_hit_scanner_unit (
	input  logic               clk,
	input  logic               arst_n,
	bphs_scan_if.sink          scan,
	bphs_result_if.source      result,
	bphs_cfg_if.sink           cfg
);
	import bphs_pkg::*;

	localparam int QUEUE_DEPTH = 3;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);

	// configuration
	logic [PATTERN_BITS-1:0] pattern_q;
	logic [LEN_BITS-1:0]     pattern_len_q;
	logic [COUNT_BITS-1:0]   hit_limit_q;

	// scan state
	logic [HIST_BITS-1:0]    history_q;
	logic [ADDRESS_BITS-1:0] offset_q;
	logic [COUNT_BITS-1:0]   hits_q;
	logic                    limit_q;

	// input stage
	logic       valid_s1;
	scan_item_t item_s1;

	// result queue, head at entry 0
	result_t             queue_q [QUEUE_DEPTH];
	result_t             queue_n [QUEUE_DEPTH];
	logic [CNT_BITS-1:0] count_q;
	logic [CNT_BITS-1:0] count_n;

	logic [LEN_BITS-1:0]     len_eff;
	logic [LEN_BITS-1:0]     len_m1;
	logic [LEN_BITS-1:0]     drop_bytes;
	logic [HIST_BITS-1:0]    hist_base;
	logic [HIST_BITS-1:0]    hist_new;
	logic [ADDRESS_BITS-1:0] off;
	logic [ADDRESS_BITS-1:0] off_next;
	logic [PATTERN_BITS-1:0] window;
	logic [PATTERN_BITS-1:0] mask;
	logic                    lim;
	logic                    hit;
	logic                    lim_after;
	logic [COUNT_BITS:0]     hits_inc;
	logic [COUNT_BITS-1:0]   hits_after;
	logic [1:0]              nres;
	logic                    fire;
	logic                    pop;
	result_t                 res_hit;
	result_t                 res_sum;
	result_t                 res0;

	always_comb begin
		if (pattern_len_q == '0) begin
			len_eff = LEN_BITS'(1);
		end else if (pattern_len_q > LEN_BITS'(MAX_PATTERN_BYTES)) begin
			len_eff = LEN_BITS'(MAX_PATTERN_BYTES);
		end else begin
			len_eff = pattern_len_q;
		end
		len_m1     = len_eff - LEN_BITS'(1);
		drop_bytes = LEN_BITS'(MAX_PATTERN_BYTES) - len_eff;

		hist_base = item_s1.region_first ? '0 : history_q;
		off       = item_s1.region_first ? '0 : offset_q;
		hist_new  = {item_s1.data_byte, hist_base[HIST_BITS-1:8]};
		off_next  = (off == '1) ? off : off + ADDRESS_BITS'(1);

		// newest len bytes, oldest of them in the low byte
		window = PATTERN_BITS'(hist_new >> {drop_bytes, 3'b000});
		for (int i = 0; i < PATTERN_BITS / 8; i++) begin
			mask[8*i +: 8] = (LEN_BITS'(i) < len_eff) ? 8'hFF : 8'h00;
		end

		lim = limit_q || (hits_q >= hit_limit_q);
		hit = !lim && (off >= ADDRESS_BITS'(len_m1))
			&& ((window & mask) == (pattern_q & mask));

		hits_inc   = {1'b0, hits_q} + (COUNT_BITS + 1)'(1);
		hits_after = hit ? hits_inc[COUNT_BITS-1:0] : hits_q;
		lim_after  = lim || (hit && (hits_inc >= {1'b0, hit_limit_q}));

		res_hit.result_kind      = KIND_HIT;
		res_hit.hit_address      = item_s1.region_base + off - ADDRESS_BITS'(len_m1);
		res_hit.hit_region_base  = item_s1.region_base;
		res_hit.hit_region_limit = item_s1.region_limit;
		res_hit.hit_number       = hits_q;
		res_hit.is_last          = !item_s1.scan_last;

		res_sum.result_kind      = KIND_SUMMARY;
		res_sum.hit_address      = '0;
		res_sum.hit_region_base  = '0;
		res_sum.hit_region_limit = '0;
		res_sum.hit_number       = hits_after;
		res_sum.is_last          = 1'b1;

		res0 = hit ? res_hit : res_sum;
		nres = {1'b0, hit} + {1'b0, item_s1.scan_last};
	end

	// the free-space check uses the registered count only, so no path runs from result.ready
	assign fire = valid_s1
		&& (({1'b0, count_q} + (CNT_BITS + 1)'(nres)) <= (CNT_BITS + 1)'(QUEUE_DEPTH));
	assign pop  = result.valid && result.ready;

	assign scan.ready     = !valid_s1 || fire;
	assign cfg.ready      = 1'b1;
	assign result.valid   = (count_q != '0);
	assign result.payload = queue_q[0];

	always_comb begin
		queue_n = queue_q;
		count_n = count_q;
		if (pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				queue_n[i] = queue_q[i + 1];
			end
			count_n = count_q - CNT_BITS'(1);
		end
		if (fire && nres != 2'd0) begin
			queue_n[count_n[IDX_BITS-1:0]] = res0;
			if (nres == 2'd2) begin
				queue_n[count_n[IDX_BITS-1:0] + IDX_BITS'(1)] = res_sum;
			end
			count_n = count_n + CNT_BITS'(nres);
		end
	end

	always_ff @(posedge clk) begin
		queue_q <= queue_n;
		if (scan.valid && scan.ready) begin
			item_s1 <= scan.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q     <= '0;
			pattern_len_q <= PATTERN_LENGTH_RESET;
			hit_limit_q   <= HIT_LIMIT_RESET;
			history_q     <= '0;
			offset_q      <= '0;
			hits_q        <= '0;
			limit_q       <= 1'b0;
			valid_s1      <= 1'b0;
			count_q       <= '0;
		end else begin
			count_q <= count_n;
			if (scan.ready) begin
				valid_s1 <= scan.valid;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_PATTERN_BYTES:  pattern_q     <= cfg.data[PATTERN_BITS-1:0];
					CFG_PATTERN_LENGTH: pattern_len_q <= cfg.data[LEN_BITS-1:0];
					CFG_HIT_LIMIT:      hit_limit_q   <= cfg.data[COUNT_BITS-1:0];
					default: ;
				endcase
			end
			if (fire) begin
				if (item_s1.scan_last) begin
					history_q <= '0;
					offset_q  <= '0;
					hits_q    <= '0;
					limit_q   <= 1'b0;
				end else begin
					history_q <= hist_new;
					offset_q  <= off_next;
					hits_q    <= hits_after;
					limit_q   <= lim_after;
				end
			end
		end
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_scan_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.scan_last |=> hits_q == '0 && offset_q == '0 && !limit_q)
		else $error("scan state not cleared after summary");

	a_no_hit_past_limit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && limit_q |-> !hit)
		else $error("hit recorded past the limit");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop && result.payload.result_kind == KIND_SUMMARY |-> result.payload.is_last)
		else $error("summary not marked last");

endmodule
